[design/scs_pkg.sv]
package scs_pkg;

    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_DASH  = 8'h2D;

    localparam int unsigned BURST_MAX = 4;

    typedef enum logic [1:0] {
        MODE_TEXT   = 2'd0,
        MODE_LINE   = 2'd1,
        MODE_BLOCK  = 2'd2,
        MODE_MARKUP = 2'd3
    } scan_mode_t;

    typedef enum logic [2:0] {
        HELD_NONE         = 3'd0,
        HELD_SLASH        = 3'd1,
        HELD_LT           = 3'd2,
        HELD_LT_BANG      = 3'd3,
        HELD_LT_BANG_DASH = 3'd4
    } held_t;

    typedef struct packed {
        logic [BURST_MAX-1:0][7:0] bytes;
        logic [1:0]                last_idx;
        logic                      no_byte;
        logic                      end_of_text;
    } burst_t;

endpackage

[design/scs_front.sv]
module scs_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      text_byte,
    input  logic            is_end,
    output logic            push,
    output scs_pkg::burst_t push_entry,
    input  logic            queue_full
);
    import scs_pkg::*;

    scan_mode_t mode_reg, mode_next;
    held_t      held_reg, held_next;
    logic [1:0] cp_reg, cp_next;
    logic       lhc_reg, lhc_next;

    logic       accept;
    logic       consumed;
    logic       is_opener;
    logic [2:0] fn;
    logic [2:0] n;
    burst_t     entry;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        case (held_reg)
            HELD_SLASH:        consumed = (text_byte == CH_SLASH) || (text_byte == CH_STAR);
            HELD_LT:           consumed = (text_byte == CH_BANG);
            HELD_LT_BANG:      consumed = (text_byte == CH_DASH);
            HELD_LT_BANG_DASH: consumed = (text_byte == CH_DASH);
            default:           consumed = 1'b0;
        endcase
        case (held_reg)
            HELD_SLASH:        fn = 3'd1;
            HELD_LT:           fn = 3'd1;
            HELD_LT_BANG:      fn = 3'd2;
            HELD_LT_BANG_DASH: fn = 3'd3;
            default:           fn = 3'd0;
        endcase
        is_opener = (text_byte == CH_SLASH) || (text_byte == CH_LT);
    end

    always_comb
    begin
        mode_next = mode_reg;
        held_next = held_reg;
        cp_next   = cp_reg;
        lhc_next  = lhc_reg;
        if (is_end)
        begin
            mode_next = MODE_TEXT;
            held_next = HELD_NONE;
            cp_next   = 2'd0;
            lhc_next  = 1'b0;
        end
        else if (text_byte == CH_NL)
        begin
            held_next = HELD_NONE;
            cp_next   = 2'd0;
            lhc_next  = 1'b0;
            if (mode_reg == MODE_LINE)
                mode_next = MODE_TEXT;
        end
        else
        begin
            case (mode_reg)
                MODE_TEXT:
                begin
                    if (consumed)
                    begin
                        case (held_reg)
                            HELD_SLASH:
                            begin
                                held_next = HELD_NONE;
                                cp_next   = 2'd0;
                                mode_next = (text_byte == CH_SLASH) ? MODE_LINE : MODE_BLOCK;
                            end
                            HELD_LT:      held_next = HELD_LT_BANG;
                            HELD_LT_BANG: held_next = HELD_LT_BANG_DASH;
                            default:
                            begin
                                held_next = HELD_NONE;
                                cp_next   = 2'd0;
                                mode_next = MODE_MARKUP;
                            end
                        endcase
                    end
                    else
                    begin
                        if (text_byte == CH_SLASH)
                            held_next = HELD_SLASH;
                        else if (text_byte == CH_LT)
                            held_next = HELD_LT;
                        else
                            held_next = HELD_NONE;
                        if ((fn != 3'd0) || !is_opener)
                            lhc_next = 1'b1;
                    end
                end
                MODE_LINE:
                begin
                end
                MODE_BLOCK:
                begin
                    if ((cp_reg != 2'd0) && (text_byte == CH_SLASH))
                    begin
                        mode_next = MODE_TEXT;
                        cp_next   = 2'd0;
                    end
                    else
                        cp_next = (text_byte == CH_STAR) ? 2'd1 : 2'd0;
                end
                default:
                begin
                    if (text_byte == CH_DASH)
                        cp_next = (cp_reg >= 2'd1) ? 2'd2 : 2'd1;
                    else if ((text_byte == CH_GT) && (cp_reg >= 2'd2))
                    begin
                        mode_next = MODE_TEXT;
                        cp_next   = 2'd0;
                    end
                    else
                        cp_next = 2'd0;
                end
            endcase
        end
    end

    always_comb
    begin
        entry = '0;
        n     = 3'd0;
        case (held_reg)
            HELD_SLASH:
                entry.bytes[0] = CH_SLASH;
            HELD_LT:
                entry.bytes[0] = CH_LT;
            HELD_LT_BANG:
            begin
                entry.bytes[0] = CH_LT;
                entry.bytes[1] = CH_BANG;
            end
            HELD_LT_BANG_DASH:
            begin
                entry.bytes[0] = CH_LT;
                entry.bytes[1] = CH_BANG;
                entry.bytes[2] = CH_DASH;
            end
            default:
            begin
            end
        endcase
        if (is_end || (text_byte == CH_NL))
        begin
            n = fn;
            if (lhc_reg || (fn != 3'd0))
            begin
                entry.bytes[n[1:0]] = CH_NL;
                n = n + 3'd1;
            end
        end
        else if ((mode_reg == MODE_TEXT) && !consumed)
        begin
            n = fn;
            if (!is_opener)
            begin
                entry.bytes[n[1:0]] = text_byte;
                n = n + 3'd1;
            end
        end
        else
        begin
            n = 3'd0;
            entry.bytes = '0;
        end
        entry.end_of_text = is_end;
        entry.no_byte     = (n == 3'd0);
        entry.last_idx    = (n == 3'd0) ? 2'd0 : 2'(n - 3'd1);
        push              = accept && (is_end || (n != 3'd0));
        push_entry        = entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_TEXT;
            held_reg <= HELD_NONE;
            cp_reg   <= 2'd0;
            lhc_reg  <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            held_reg <= held_next;
            cp_reg   <= cp_next;
            lhc_reg  <= lhc_next;
        end
    end

endmodule

[design/scs_queue.sv]
module scs_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  scs_pkg::burst_t push_entry,
    output logic            full,
    output logic            head_valid,
    output scs_pkg::burst_t head_entry,
    input  logic            pop
);
    import scs_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    burst_t             entries_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = entries_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!do_push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

[design/scs_back.sv]
module scs_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  scs_pkg::burst_t head_entry,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      out_byte,
    output logic            out_no_byte,
    output logic            out_last
);
    import scs_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       no_byte_reg;
    logic       last_reg;
    logic       load;
    logic       at_last;

    assign load      = head_valid && (!valid_reg || out_ready);
    assign at_last   = (idx_reg == head_entry.last_idx);
    assign pop       = load && at_last;
    assign idx_next  = at_last ? 2'd0 : idx_reg + 2'd1;

    assign out_valid   = valid_reg;
    assign out_byte    = byte_reg;
    assign out_no_byte = no_byte_reg;
    assign out_last    = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= idx_next;
            end
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg    <= head_entry.bytes[idx_reg];
            no_byte_reg <= head_entry.no_byte;
            last_reg    <= head_entry.end_of_text && at_last;
        end
    end

endmodule

[design/source_comment_stripper.sv]
// Source comment stripper.
// Input stream (s_axis): one byte of text per transaction in tdata; tlast high
// marks the end of the text, and tdata is then ignored.
// Output stream (m_axis): one byte of stripped text per transaction in tdata;
// tuser flags a transaction that carries no byte (an empty end flush); tlast
// marks the final transaction caused by the end marker.
// Line, block and markup comments are removed, empty lines dropped.
// Each input byte yields zero to four output bytes (held opener bytes plus
// the current one). Input is taken every cycle while the burst queue between
// the classifier and the serialiser has room; output runs at one byte per
// cycle while m_axis_tready is high, so sustained throughput is one input per
// cycle unless held-back opener bytes are released, in which case the output
// port sets the rate. Output bytes pass the queue, then the output register.
// Reset clears the scan state, empties the queue and drops m_axis_tvalid.
// A stalled receiver holds the output register; the queue then fills and
// s_axis_tready falls once QUEUE_DEPTH bursts are waiting.
module source_comment_stripper #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] text_byte
    input  logic       s_axis_tlast,   // is_end
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tuser,   // [0] no_byte
    output logic       m_axis_tlast    // end_of_text
);
    import scs_pkg::*;

    logic   push;
    burst_t push_entry;
    logic   queue_full;
    logic   head_valid;
    burst_t head_entry;
    logic   pop;

    scs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .text_byte  (s_axis_tdata),
        .is_end     (s_axis_tlast),
        .push       (push),
        .push_entry (push_entry),
        .queue_full (queue_full)
    );

    scs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop)
    );

    scs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_entry  (head_entry),
        .pop         (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_byte    (m_axis_tdata),
        .out_no_byte (m_axis_tuser),
        .out_last    (m_axis_tlast)
    );

endmodule
